>>> rtl/vlm_pkg.sv
// shared types and codes for the vending lane motor run controller
// no dependencies; used by every module in rtl
`timescale 1ns / 1ps

package vlm_pkg;

    // input beat kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // run phase codes
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_STARTING = 2'd1;
    localparam logic [1:0] PHASE_RUNNING  = 2'd2;

    // lane mode codes
    localparam logic [1:0] MODE_UNKNOWN  = 2'd0;
    localparam logic [1:0] MODE_SPRING   = 2'h1;
    localparam logic [1:0] MODE_CONVEYOR = 2'h2;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_BLOCKED = 2'd2;

    // register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DELAY     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN_TIME = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COIL_PULSE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONVEYOR_PULSE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TICKS    = 4'd7;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [15:0] stop_delay;
        logic [15:0] timeout_ticks;
        logic [15:0] pulse_min_time;
        logic [15:0] coil_pulse_time;
        logic [15:0] conveyor_pulse_time;
        logic [11:0] current_limit;
        logic [15:0] block_ticks;
    } t_cfg;

    typedef struct packed {
        logic        enable_flag;
        logic [1:0]  phase;
        logic [3:0]  sel_x;
        logic [2:0]  sel_y;
        logic [15:0] run_ticks;
        logic [15:0] trigger_tick;
        logic [15:0] overcurrent_count;
        logic [1:0]  mode_reg;
        logic [1:0]  err_reg;
        logic        pos_err_reg;
        logic        fall_latch;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  lane_x;
        logic [2:0]  lane_y;
        logic        pos_level;
        logic        pos_falling;
        logic [15:0] pulse_high_time;
        logic [11:0] motor_current;
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic        drive_on;
        logic [3:0]  drive_x;
        logic [2:0]  drive_y;
        logic [1:0]  run_phase;
        logic [1:0]  lane_mode;
        logic [1:0]  error_code;
        logic        position_error;
        logic        finished;
    } t_result;

endpackage

>>> rtl/vend_lane_motor_run_controller_core.sv
// top level of the vending lane motor run controller
// depends on vlm_pkg, vlm_cfg_regs and vlm_step_logic
`timescale 1ns / 1ps

// Runs the motor of one lane in a vending lane matrix. Every input beat (a tick,
// a start request or a stop request) produces exactly one status beat on the
// master side in the cycle after it is taken. A new beat can be taken in every
// cycle: the whole update is one pass of compare and counter logic between the
// run state register and the output register, and the input side stays ready
// while a result waits as long as the output register is being drained in the
// same cycle. Sustained rate is one beat per clock while the master side keeps
// tready high. The configuration write channel is always ready; write registers
// only while no beats are in flight.

module vend_lane_motor_run_controller_core #(
    parameter int COLUMNS          = 16,
    parameter int ROWS             = 8,
    parameter int MODE_CHECK_TICKS = 300
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // lane_x[3:0] lane_y[6:4] pos_level[7] pos_falling[8] pulse_high_time[24:9]
    // motor_current[36:25], zero pad [39:37]
    input  logic [vlm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // accepted[0] drive_on[1] drive_x[5:2] drive_y[8:6] run_phase[10:9]
    // lane_mode[12:11] error_code[14:13] position_error[15] finished[16],
    // zero pad [23:17]
    output logic [vlm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    vlm_pkg::t_cfg    cfg;
    vlm_pkg::t_item   item;
    vlm_pkg::t_state  r_state;
    vlm_pkg::t_state  n_state;
    vlm_pkg::t_result result;

    logic                           r_m_tvalid;
    logic [vlm_pkg::OUT_DATA_W-1:0] r_m_tdata;
    logic                           in_beat;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    vlm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // unpack the incoming beat
    always_comb begin
        item.kind            = i_s_axis_tuser;
        item.lane_x          = i_s_axis_tdata[3:0];
        item.lane_y          = i_s_axis_tdata[6:4];
        item.pos_level       = i_s_axis_tdata[7];
        item.pos_falling     = i_s_axis_tdata[8];
        item.pulse_high_time = i_s_axis_tdata[24:9];
        item.motor_current   = i_s_axis_tdata[36:25];
    end

    vlm_step_logic #(
        .COLUMNS          (COLUMNS),
        .ROWS             (ROWS),
        .MODE_CHECK_TICKS (MODE_CHECK_TICKS)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (item),
        .o_next   (n_state),
        .o_result (result)
    );

    // take a beat whenever the output register is empty or draining now
    assign o_s_axis_tready = !r_m_tvalid || i_m_axis_tready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    // run state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // output register: valid is control, data is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (in_beat) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_m_tdata <= {7'd0,
                          result.finished,
                          result.position_error,
                          result.error_code,
                          result.lane_mode,
                          result.run_phase,
                          result.drive_y,
                          result.drive_x,
                          result.drive_on,
                          result.accepted};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

>>> rtl/vlm_cfg_regs.sv
// configuration register file of the lane motor run controller
// depends on vlm_pkg
`timescale 1ns / 1ps

module vlm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]  i_data,
    output vlm_pkg::t_cfg                   o_cfg
);

    vlm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay         <= 16'd20;
            r_cfg.stop_delay          <= 16'd50;
            r_cfg.timeout_ticks       <= 16'd1000;
            r_cfg.pulse_min_time      <= 16'd5;
            r_cfg.coil_pulse_time     <= 16'd100;
            r_cfg.conveyor_pulse_time <= 16'd10;
            r_cfg.current_limit       <= 12'd2000;
            r_cfg.block_ticks         <= 16'd30;
        end else if (i_wr) begin
            unique case (i_index)
                vlm_pkg::REG_START_DELAY:    r_cfg.start_delay         <= i_data;
                vlm_pkg::REG_STOP_DELAY:     r_cfg.stop_delay          <= i_data;
                vlm_pkg::REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks       <= i_data;
                vlm_pkg::REG_PULSE_MIN_TIME: r_cfg.pulse_min_time      <= i_data;
                vlm_pkg::REG_COIL_PULSE:     r_cfg.coil_pulse_time     <= i_data;
                vlm_pkg::REG_CONVEYOR_PULSE: r_cfg.conveyor_pulse_time <= i_data;
                vlm_pkg::REG_CURRENT_LIMIT:  r_cfg.current_limit       <= i_data[11:0];
                vlm_pkg::REG_BLOCK_TICKS:    r_cfg.block_ticks         <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/vlm_step_logic.sv
// single-beat update of the run state and the status result
// depends on vlm_pkg; purely combinational
`timescale 1ns / 1ps

module vlm_step_logic #(
    parameter int COLUMNS          = 16,
    parameter int ROWS             = 8,
    parameter int MODE_CHECK_TICKS = 300
) (
    input  vlm_pkg::t_cfg    i_cfg,
    input  vlm_pkg::t_state  i_state,
    input  vlm_pkg::t_item   i_item,
    output vlm_pkg::t_state  o_next,
    output vlm_pkg::t_result o_result
);

    localparam logic [15:0] MODE_CHECK_AT = 16'(MODE_CHECK_TICKS);

    vlm_pkg::t_state n_state;
    logic            accepted;
    logic            active;
    logic [15:0]     rt_inc;
    logic [15:0]     trig_dist;
    logic            lane_ok;

    assign active    = (i_state.phase != vlm_pkg::PHASE_IDLE);
    assign rt_inc    = i_state.run_ticks + 16'd1;
    assign trig_dist = rt_inc - i_state.trigger_tick;
    assign lane_ok   = (32'(i_item.lane_x) < 32'(COLUMNS)) && (32'(i_item.lane_y) < 32'(ROWS));

    always_comb begin
        n_state  = i_state;
        accepted = 1'b0;
        case (i_item.kind)
            vlm_pkg::KIND_TICK: begin
                if (i_state.enable_flag && active && i_item.pos_falling) begin
                    n_state.fall_latch = 1'b1;
                end
                if (!i_state.enable_flag) begin
                    n_state.phase = vlm_pkg::PHASE_IDLE;
                end else if (!active) begin
                    // first tick after start: energize and clear run bookkeeping
                    n_state.phase             = vlm_pkg::PHASE_STARTING;
                    n_state.run_ticks         = 16'd0;
                    n_state.trigger_tick      = 16'd0;
                    n_state.err_reg           = vlm_pkg::ERR_NONE;
                    n_state.overcurrent_count = 16'd0;
                    n_state.mode_reg          = vlm_pkg::MODE_UNKNOWN;
                end else begin
                    n_state.run_ticks = rt_inc;
                    if (rt_inc == i_cfg.start_delay) begin
                        n_state.fall_latch  = 1'b0;
                        n_state.pos_err_reg = i_item.pos_level;
                        n_state.phase       = vlm_pkg::PHASE_RUNNING;
                    end else if (rt_inc > i_cfg.start_delay) begin
                        if (i_state.trigger_tick != 16'd0) begin
                            // conveyor run-on after trigger
                            if (trig_dist > i_cfg.stop_delay) begin
                                n_state.enable_flag  = 1'b0;
                                n_state.phase        = vlm_pkg::PHASE_IDLE;
                                n_state.trigger_tick = 16'd0;
                            end
                        end else if (n_state.fall_latch) begin
                            n_state.fall_latch = 1'b0;
                            if (i_item.pulse_high_time > i_cfg.pulse_min_time) begin
                                if (i_item.pulse_high_time > i_cfg.coil_pulse_time) begin
                                    n_state.mode_reg     = vlm_pkg::MODE_SPRING;
                                    n_state.enable_flag  = 1'b0;
                                    n_state.phase        = vlm_pkg::PHASE_IDLE;
                                    n_state.trigger_tick = 16'd0;
                                end else if (i_item.pulse_high_time >
                                             i_cfg.conveyor_pulse_time) begin
                                    n_state.mode_reg     = vlm_pkg::MODE_CONVEYOR;
                                    n_state.trigger_tick = rt_inc;
                                end
                            end
                        end else if (rt_inc == i_cfg.timeout_ticks) begin
                            n_state.err_reg      = vlm_pkg::ERR_TIMEOUT;
                            n_state.enable_flag  = 1'b0;
                            n_state.phase        = vlm_pkg::PHASE_IDLE;
                            n_state.trigger_tick = 16'd0;
                        end else if (i_item.motor_current > i_cfg.current_limit) begin
                            if (i_state.overcurrent_count < i_cfg.block_ticks) begin
                                n_state.overcurrent_count = i_state.overcurrent_count + 16'd1;
                            end else begin
                                n_state.err_reg      = vlm_pkg::ERR_BLOCKED;
                                n_state.enable_flag  = 1'b0;
                                n_state.phase        = vlm_pkg::PHASE_IDLE;
                                n_state.trigger_tick = 16'd0;
                            end
                        end else if (rt_inc == MODE_CHECK_AT) begin
                            n_state.mode_reg = i_item.pos_level ? vlm_pkg::MODE_SPRING
                                                                : vlm_pkg::MODE_CONVEYOR;
                        end
                    end
                end
            end
            vlm_pkg::KIND_START: begin
                if (!active && lane_ok) begin
                    n_state.enable_flag = 1'b1;
                    n_state.sel_x       = i_item.lane_x;
                    n_state.sel_y       = i_item.lane_y;
                    accepted            = 1'b1;
                end
            end
            vlm_pkg::KIND_STOP: begin
                n_state.enable_flag = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.accepted       = accepted;
        o_result.drive_on       = (n_state.phase != vlm_pkg::PHASE_IDLE);
        o_result.drive_x        = o_result.drive_on ? n_state.sel_x : 4'd0;
        o_result.drive_y        = o_result.drive_on ? n_state.sel_y : 3'd0;
        o_result.run_phase      = n_state.phase;
        o_result.lane_mode      = n_state.mode_reg;
        o_result.error_code     = n_state.err_reg;
        o_result.position_error = n_state.pos_err_reg;
        o_result.finished       = active && !o_result.drive_on;
    end

    assign o_next = n_state;

endmodule

>>> verif/lane_run_checker.sv
// status checker for the vending lane motor run controller: tracks config writes,
// predicts one status beat per input beat and compares the returned status fields
// depends on vlm_pkg only
`timescale 1ns / 1ps

module lane_run_checker #(
    parameter int COLUMNS          = 16,
    parameter int ROWS             = 8,
    parameter int MODE_CHECK_TICKS = 300
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [vlm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic [1:0]                       i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [vlm_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    vlm_pkg::t_cfg    reg_shadow;
    vlm_pkg::t_state  lane_run;
    vlm_pkg::t_result expected_status[$];
    int               status_beats;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_fail_count < 100)
            $display("status beat %0d: %s got %0h want %0h", status_beats, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic stop_run();
        lane_run.enable_flag  = 1'b0;
        lane_run.phase        = vlm_pkg::PHASE_IDLE;
        lane_run.trigger_tick = '0;
    endtask

    // next run state and status for one input beat
    task automatic advance_lane_run(input vlm_pkg::t_item beat,
                                    output vlm_pkg::t_result rs);
        logic        was_on;
        logic        on;
        logic        took;
        logic [15:0] since_trig;
        was_on = (lane_run.phase != vlm_pkg::PHASE_IDLE);
        took   = 1'b0;
        case (beat.kind)
            vlm_pkg::KIND_TICK: begin
                if (lane_run.enable_flag && lane_run.phase != vlm_pkg::PHASE_IDLE &&
                    beat.pos_falling)
                    lane_run.fall_latch = 1'b1;
                if (!lane_run.enable_flag) begin
                    lane_run.phase = vlm_pkg::PHASE_IDLE;
                end else if (lane_run.phase == vlm_pkg::PHASE_IDLE) begin
                    lane_run.phase             = vlm_pkg::PHASE_STARTING;
                    lane_run.run_ticks         = '0;
                    lane_run.trigger_tick      = '0;
                    lane_run.err_reg           = vlm_pkg::ERR_NONE;
                    lane_run.overcurrent_count = '0;
                    lane_run.mode_reg          = vlm_pkg::MODE_UNKNOWN;
                end else begin
                    lane_run.run_ticks = lane_run.run_ticks + 16'd1;
                    if (lane_run.run_ticks == reg_shadow.start_delay) begin
                        lane_run.fall_latch  = 1'b0;
                        lane_run.pos_err_reg = beat.pos_level;
                        lane_run.phase       = vlm_pkg::PHASE_RUNNING;
                    end else if (lane_run.run_ticks > reg_shadow.start_delay) begin
                        since_trig = lane_run.run_ticks - lane_run.trigger_tick;
                        if (lane_run.trigger_tick != 16'd0) begin
                            if (since_trig > reg_shadow.stop_delay)
                                stop_run();
                        end else if (lane_run.fall_latch) begin
                            lane_run.fall_latch = 1'b0;
                            if (beat.pulse_high_time > reg_shadow.pulse_min_time) begin
                                if (beat.pulse_high_time > reg_shadow.coil_pulse_time) begin
                                    lane_run.mode_reg = vlm_pkg::MODE_SPRING;
                                    stop_run();
                                end else if (beat.pulse_high_time >
                                             reg_shadow.conveyor_pulse_time) begin
                                    lane_run.mode_reg     = vlm_pkg::MODE_CONVEYOR;
                                    lane_run.trigger_tick = lane_run.run_ticks;
                                end
                            end
                        end else if (lane_run.run_ticks == reg_shadow.timeout_ticks) begin
                            lane_run.err_reg = vlm_pkg::ERR_TIMEOUT;
                            stop_run();
                        end else if (beat.motor_current > reg_shadow.current_limit) begin
                            if (lane_run.overcurrent_count < reg_shadow.block_ticks) begin
                                lane_run.overcurrent_count = lane_run.overcurrent_count + 16'd1;
                            end else begin
                                lane_run.err_reg = vlm_pkg::ERR_BLOCKED;
                                stop_run();
                            end
                        end else if (int'(lane_run.run_ticks) == MODE_CHECK_TICKS) begin
                            lane_run.mode_reg = beat.pos_level ? vlm_pkg::MODE_SPRING
                                                               : vlm_pkg::MODE_CONVEYOR;
                        end
                    end
                end
            end
            vlm_pkg::KIND_START: begin
                if (lane_run.phase == vlm_pkg::PHASE_IDLE && int'(beat.lane_x) < COLUMNS &&
                    int'(beat.lane_y) < ROWS) begin
                    lane_run.enable_flag = 1'b1;
                    lane_run.sel_x       = beat.lane_x;
                    lane_run.sel_y       = beat.lane_y;
                    took                 = 1'b1;
                end
            end
            vlm_pkg::KIND_STOP: begin
                lane_run.enable_flag = 1'b0;
            end
            default: ;
        endcase
        on                = (lane_run.phase != vlm_pkg::PHASE_IDLE);
        rs.accepted       = took;
        rs.drive_on       = on;
        rs.drive_x        = on ? lane_run.sel_x : 4'd0;
        rs.drive_y        = on ? lane_run.sel_y : 3'd0;
        rs.run_phase      = lane_run.phase;
        rs.lane_mode      = lane_run.mode_reg;
        rs.error_code     = lane_run.err_reg;
        rs.position_error = lane_run.pos_err_reg;
        rs.finished       = was_on && !on;
    endtask

    always @(posedge i_clk) begin : watch
        vlm_pkg::t_item   beat_in;
        vlm_pkg::t_result want;
        vlm_pkg::t_result got;
        if (!i_rst_n) begin
            reg_shadow.start_delay         = 16'd20;
            reg_shadow.stop_delay          = 16'd50;
            reg_shadow.timeout_ticks       = 16'd1000;
            reg_shadow.pulse_min_time      = 16'd5;
            reg_shadow.coil_pulse_time     = 16'd100;
            reg_shadow.conveyor_pulse_time = 16'd10;
            reg_shadow.current_limit       = 12'd2000;
            reg_shadow.block_ticks         = 16'd30;
            lane_run = '0;
            expected_status.delete();
            o_fail_count = 0;
            status_beats = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vlm_pkg::REG_START_DELAY:    reg_shadow.start_delay         = i_cfg_data;
                    vlm_pkg::REG_STOP_DELAY:     reg_shadow.stop_delay          = i_cfg_data;
                    vlm_pkg::REG_TIMEOUT_TICKS:  reg_shadow.timeout_ticks       = i_cfg_data;
                    vlm_pkg::REG_PULSE_MIN_TIME: reg_shadow.pulse_min_time      = i_cfg_data;
                    vlm_pkg::REG_COIL_PULSE:     reg_shadow.coil_pulse_time     = i_cfg_data;
                    vlm_pkg::REG_CONVEYOR_PULSE: reg_shadow.conveyor_pulse_time = i_cfg_data;
                    vlm_pkg::REG_CURRENT_LIMIT:  reg_shadow.current_limit = i_cfg_data[11:0];
                    vlm_pkg::REG_BLOCK_TICKS:    reg_shadow.block_ticks         = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.accepted       = i_m_tdata[0];
                got.drive_on       = i_m_tdata[1];
                got.drive_x        = i_m_tdata[5:2];
                got.drive_y        = i_m_tdata[8:6];
                got.run_phase      = i_m_tdata[10:9];
                got.lane_mode      = i_m_tdata[12:11];
                got.error_code     = i_m_tdata[14:13];
                got.position_error = i_m_tdata[15];
                got.finished       = i_m_tdata[16];
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata[15:0], 16'd0);
                end else begin
                    want = expected_status.pop_front();
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("drive_on", got.drive_on, want.drive_on);
                    check_field("drive_x", got.drive_x, want.drive_x);
                    check_field("drive_y", got.drive_y, want.drive_y);
                    check_field("run_phase", got.run_phase, want.run_phase);
                    check_field("lane_mode", got.lane_mode, want.lane_mode);
                    check_field("error_code", got.error_code, want.error_code);
                    check_field("position_error", got.position_error, want.position_error);
                    check_field("finished", got.finished, want.finished);
                end
                status_beats++;
            end
            if (i_s_tvalid && i_s_tready) begin
                beat_in.kind            = i_s_tuser;
                beat_in.lane_x          = i_s_tdata[3:0];
                beat_in.lane_y          = i_s_tdata[6:4];
                beat_in.pos_level       = i_s_tdata[7];
                beat_in.pos_falling     = i_s_tdata[8];
                beat_in.pulse_high_time = i_s_tdata[24:9];
                beat_in.motor_current   = i_s_tdata[36:25];
                advance_lane_run(beat_in, want);
                expected_status.push_back(want);
            end
        end
        o_pending = expected_status.size();
    end

endmodule

>>> verif/testbench.sv
// top of the lane motor run controller testbench: clock, reset, stimulus and verdict
// depends on vlm_pkg, lane_run_checker and the rtl core
`timescale 1ns / 1ps

module testbench;

    localparam int COLUMNS          = 16;
    localparam int ROWS             = 8;
    localparam int MODE_CHECK_TICKS = 300;
    // budget for about 1400 beats under the heaviest idling, plus register writes,
    // taken about ten times over
    localparam int CYCLE_LIMIT = 40000;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic [vlm_pkg::IN_DATA_W-1:0]  s_data    = '0;
    logic [1:0]                     s_user    = vlm_pkg::KIND_TICK;
    logic                           m_ready   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [vlm_pkg::CFG_IDX_W-1:0]  cfg_idx   = vlm_pkg::REG_START_DELAY;
    logic [vlm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    wire                            s_ready;
    wire                            m_valid;
    wire [vlm_pkg::OUT_DATA_W-1:0]  m_data;
    wire                            cfg_ready;
    int                             fail_count;
    int                             pending_cnt;

    // idling percentages of the current phase
    int            snd_idle_pct  = 0;
    int            rcv_stall_pct = 0;
    int            cycle_cnt     = 0;
    // register values last written, used to aim the random stimulus
    vlm_pkg::t_cfg cur_cfg;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    vend_lane_motor_run_controller_core #(
        .COLUMNS          (COLUMNS),
        .ROWS             (ROWS),
        .MODE_CHECK_TICKS (MODE_CHECK_TICKS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // lane_x, lane_y, pos_level, pos_falling, pulse_high_time, motor_current, pad
        .i_s_axis_tdata  (s_data),
        // kind
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // accepted, drive_on, drive_x, drive_y, run_phase, lane_mode, error_code,
        // position_error, finished, pad
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    lane_run_checker #(
        .COLUMNS          (COLUMNS),
        .ROWS             (ROWS),
        .MODE_CHECK_TICKS (MODE_CHECK_TICKS)
    ) status_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // receiver back-pressure, one decision per falling edge
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    function automatic vlm_pkg::t_item mk_item(input logic [1:0] k, input logic [3:0] x,
                                               input logic [2:0] y, input logic lvl,
                                               input logic fall, input logic [15:0] pulse,
                                               input logic [11:0] cur);
        vlm_pkg::t_item it;
        it.kind            = k;
        it.lane_x          = x;
        it.lane_y          = y;
        it.pos_level       = lvl;
        it.pos_falling     = fall;
        it.pulse_high_time = pulse;
        it.motor_current   = cur;
        return it;
    endfunction

    // a tick aimed at the current thresholds: pulse widths on both sides of each
    // limit, and currents above the limit often enough to reach the blocked error
    function automatic vlm_pkg::t_item lane_tick();
        logic [15:0] pulse;
        logic [11:0] cur;
        case ($urandom_range(7))
            0:       pulse = cur_cfg.pulse_min_time;
            1:       pulse = cur_cfg.pulse_min_time + 16'd1;
            2:       pulse = cur_cfg.conveyor_pulse_time;
            3:       pulse = cur_cfg.conveyor_pulse_time + 16'd1;
            4:       pulse = cur_cfg.coil_pulse_time;
            5:       pulse = cur_cfg.coil_pulse_time + 16'd1;
            default: pulse = 16'($urandom);
        endcase
        if ($urandom_range(99) < 25 && cur_cfg.current_limit != 12'hFFF)
            cur = 12'($urandom_range(int'(cur_cfg.current_limit) + 1, 4095));
        else
            cur = 12'($urandom_range(0, int'(cur_cfg.current_limit)));
        return mk_item(vlm_pkg::KIND_TICK, 4'($urandom), 3'($urandom), 1'($urandom),
                       $urandom_range(99) < 12, pulse, cur);
    endfunction

    // present one beat from a falling edge and hold it until it is taken;
    // tvalid stays high afterwards so back-to-back beats need no re-raise
    task automatic send_beat(input vlm_pkg::t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.kind;
        s_data  <= {3'b000, it.motor_current, it.pulse_high_time, it.pos_falling,
                    it.pos_level, it.lane_y, it.lane_x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // a beat with every field random
    function automatic vlm_pkg::t_item noise_item(input logic [1:0] k);
        return mk_item(k, 4'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                       16'($urandom), 12'($urandom));
    endfunction

    // sender holds off until every outstanding status beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [vlm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // registers only change with the core idle, after every status beat has come back
    task automatic apply_cfg(input vlm_pkg::t_cfg c);
        wait_drained();
        repeat (3) @(negedge i_clk);
        write_reg(vlm_pkg::REG_START_DELAY, c.start_delay);
        write_reg(vlm_pkg::REG_STOP_DELAY, c.stop_delay);
        write_reg(vlm_pkg::REG_TIMEOUT_TICKS, c.timeout_ticks);
        write_reg(vlm_pkg::REG_PULSE_MIN_TIME, c.pulse_min_time);
        write_reg(vlm_pkg::REG_COIL_PULSE, c.coil_pulse_time);
        write_reg(vlm_pkg::REG_CONVEYOR_PULSE, c.conveyor_pulse_time);
        write_reg(vlm_pkg::REG_CURRENT_LIMIT, {4'd0, c.current_limit});
        write_reg(vlm_pkg::REG_BLOCK_TICKS, c.block_ticks);
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // mostly well-formed runs (start, a train of ticks, stop) with random content,
    // mixed with bursts of raw noise and runs broken by stray stops or starts
    task automatic run_random_traffic(input int budget);
        int sent;
        int n;
        int i;
        int cap;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_beat(noise_item(2'($urandom_range(3))));
                sent += n;
            end else begin
                cap = (cur_cfg.timeout_ticks < 16'd64) ? int'(cur_cfg.timeout_ticks) + 6 : 70;
                if (cap < 3)
                    cap = 3;
                send_beat(noise_item(vlm_pkg::KIND_START));
                n = $urandom_range(3, cap);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(99) < 4)
                        send_beat(noise_item(2'($urandom_range(1, 3))));
                    else
                        send_beat(lane_tick());
                end
                sent += n + 1;
                if ($urandom_range(99) < 70) begin
                    send_beat(mk_item(vlm_pkg::KIND_STOP, 4'($urandom), 3'($urandom),
                                      0, 0, 0, 0));
                    send_beat(lane_tick());
                    sent += 2;
                end
            end
        end
    endtask

    // watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        vlm_pkg::t_cfg c;
        int            ph;
        int            sub;
        cur_cfg.start_delay         = 16'd20;
        cur_cfg.stop_delay          = 16'd50;
        cur_cfg.timeout_ticks       = 16'd1000;
        cur_cfg.pulse_min_time      = 16'd5;
        cur_cfg.coil_pulse_time     = 16'd100;
        cur_cfg.conveyor_pulse_time = 16'd10;
        cur_cfg.current_limit       = 12'd2000;
        cur_cfg.block_ticks         = 16'd30;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values: drivers come on, check point not yet reached
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd3, 3'd5, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 1, 1, 16'd200, 12'd4095));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 1, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));

        // directed part with short delays
        c.start_delay = 16'd2;  c.stop_delay = 16'd1;  c.timeout_ticks = 16'd9;
        c.pulse_min_time = 16'd5;  c.coil_pulse_time = 16'd100;
        c.conveyor_pulse_time = 16'd10;  c.current_limit = 12'd2000;  c.block_ticks = 16'd1;
        apply_cfg(c);
        send_beat(mk_item(vlm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0));        // stop while idle
        send_beat(mk_item(2'd3, 4'd9, 3'd2, 1, 1, 16'hFFFF, 12'hFFF));  // unused kind
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd15, 3'd7, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0));        // disarm first
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd15, 3'd7, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd0, 3'd0, 0, 0, 0, 0)); // lane replaced
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));        // drivers on
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd5, 3'd5, 0, 0, 0, 0)); // refused
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 1, 16'd50, 0));   // edge latched early
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 1, 0, 0, 0));        // position check
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 1, 16'd5, 0));    // pulse too short
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 1, 16'd11, 0));   // conveyor trigger
        wait_drained();
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));        // stop delay passed
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd7, 3'd3, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 1, 16'hFFFF, 0)); // spring: stops
        send_beat(mk_item(vlm_pkg::KIND_START, 4'd1, 3'd6, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 12'hFFF));  // overcurrent counted
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 12'd0));    // count kept
        send_beat(mk_item(vlm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 12'hFFF));  // blocked

        // random part: four idling phases, three register settings each,
        // the all-zero and all-ones settings among them
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 60; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 60; end
                default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
            endcase
            for (sub = 0; sub < 3; sub++) begin
                if (ph == 0 && sub == 0) begin
                    c = '0;
                end else if (ph == 1 && sub == 0) begin
                    c = '1;
                end else begin
                    c.start_delay         = 16'($urandom_range(0, 10));
                    c.stop_delay          = 16'($urandom_range(0, 8));
                    c.timeout_ticks       = 16'($urandom_range(0, 70));
                    c.pulse_min_time      = 16'($urandom_range(0, 20));
                    c.conveyor_pulse_time = c.pulse_min_time + 16'($urandom_range(0, 15));
                    c.coil_pulse_time     = c.conveyor_pulse_time + 16'($urandom_range(0, 40));
                    c.current_limit       = 12'($urandom_range(0, 4095));
                    c.block_ticks         = 16'($urandom_range(0, 10));
                end
                apply_cfg(c);
                run_random_traffic(92);
            end
        end

        // drain and let the pipeline settle before the verdict
        wait_drained();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/vlm_pkg.sv
rtl/vlm_cfg_regs.sv
rtl/vlm_step_logic.sv
rtl/vend_lane_motor_run_controller_core.sv
verif/lane_run_checker.sv
verif/testbench.sv
